// File: hw/rtl/tgamd_pkg.sv
// Package for the tilt gesture armed motor drive: shared types, constants and
// the reverse duty table. Depends on nothing; every other RTL file imports it.
package tgamd_pkg;

    // Widths fixed by the item fields and configuration registers.
    localparam int GYRO_W = 17;
    localparam int ROLL_W = 16;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int DUTY_W = 8;
    localparam int STEP_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int DEG_W  = 9;     // whole degrees of roll magnitude, up to 327

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING_ANGLE    = 2'd2;

    localparam logic [CFG_W-1:0] RATE_THRESHOLD_RST     = 16'd70;
    localparam logic [CFG_W-1:0] DURATION_TOLERANCE_RST = 16'd200;
    localparam logic [CFG_W-1:0] MIN_SWING_ANGLE_RST    = 16'd1500;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x up to 32768.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 29;

    // Drive law thresholds, in whole degrees below level.
    localparam int BRAKE_DEG     = 20;
    localparam int FWD_FULL_DEG  = 45;
    localparam int FWD_ZERO_DEG  = 60;
    localparam int FWD_GAIN      = 255 / 15;
    localparam int REV_START_DEG = 90;
    localparam int REV_FULL_DEG  = 100;
    localparam logic [DUTY_W-1:0] DUTY_MAX     = 8'd255;
    localparam logic [DUTY_W-1:0] REV_DUTY_MAX = 8'd128;

    // Gesture steps.
    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_ARMED = 4'd4;
    localparam logic [STEP_W-1:0] STEP_TOP   = 4'd8;

    typedef enum logic [1:0] {
        DIR_STILL = 2'b00,
        DIR_UP    = 2'b01,
        DIR_DOWN  = 2'b10
    } dir_t;

    // One classified sample, handed from the front to the back.
    typedef struct packed {
        logic              brake_zone;   // roll above the brake angle
        logic [DUTY_W-1:0] fwd_duty;     // forward duty if not braking
        logic [DUTY_W-1:0] rev_duty;     // backward duty if forward is zero
        logic              swing_valid;  // a swing finished on this sample
        logic              swing_up;     // direction of that swing
        logic              angle_small;  // swing below the minimum angle
        logic [TIME_W-1:0] swing_len;    // swing length in ms
    } item_t;

    // Backward duty for one to nine degrees past the reverse start angle:
    // k * 128 / 10, truncated.
    function automatic logic [DUTY_W-1:0] rev_table(input logic [3:0] k);
        logic [DUTY_W-1:0] d;
        unique case (k)
            4'd1:    d = 8'd12;
            4'd2:    d = 8'd25;
            4'd3:    d = 8'd38;
            4'd4:    d = 8'd51;
            4'd5:    d = 8'd64;
            4'd6:    d = 8'd76;
            4'd7:    d = 8'd89;
            4'd8:    d = 8'd102;
            4'd9:    d = 8'd115;
            default: d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/tgamd_front.sv
// Front end: classifies each accepted sample into a direction, detects the end
// of a swing and works out the drive duties from the roll. Uses tgamd_pkg.
module tgamd_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 accept,
    input  logic signed [tgamd_pkg::GYRO_W-1:0]  gyro_rate,
    input  logic signed [tgamd_pkg::ROLL_W-1:0]  roll_angle,
    input  logic        [tgamd_pkg::TIME_W-1:0]  time_ms,
    input  logic        [tgamd_pkg::CFG_W-1:0]   rate_threshold,
    input  logic        [tgamd_pkg::CFG_W-1:0]   min_swing_angle,
    output tgamd_pkg::item_t                     item
);
    import tgamd_pkg::*;

    dir_t              dir_reg;
    logic [ROLL_W-1:0] still_angle_reg;
    logic [TIME_W-1:0] still_time_reg;

    logic [GYRO_W-1:0] gyro_bits;
    logic [GYRO_W-1:0] gyro_mag;
    logic [ROLL_W-1:0] roll_bits;
    logic [ROLL_W-1:0] roll_mag;
    logic [PROD_W-1:0] roll_prod;
    logic [DEG_W-1:0]  roll_deg;
    logic [DEG_W-1:0]  fwd_span;
    logic [DEG_W-1:0]  rev_span;
    logic [ROLL_W:0]   angle_diff;
    logic [ROLL_W:0]   angle_mag;
    dir_t              cur_dir;
    logic              restart;

    always_comb begin
        gyro_bits = gyro_rate;
        gyro_mag  = gyro_bits[GYRO_W-1] ? (GYRO_W'(0) - gyro_bits) : gyro_bits;
        if (gyro_mag > {1'b0, rate_threshold}) begin
            cur_dir = gyro_bits[GYRO_W-1] ? DIR_UP : DIR_DOWN;
        end else begin
            cur_dir = DIR_STILL;
        end
        restart = (cur_dir != dir_reg) || (cur_dir == DIR_STILL);

        // Whole degrees of roll magnitude; only negative roll is driven.
        roll_bits = roll_angle;
        roll_mag  = roll_bits[ROLL_W-1] ? (ROLL_W'(0) - roll_bits) : roll_bits;
        roll_prod = PROD_W'(roll_mag) * PROD_W'(RECIP_100);
        roll_deg  = DEG_W'(roll_prod >> RECIP_SHIFT);
        fwd_span  = DEG_W'(FWD_ZERO_DEG) - roll_deg;
        rev_span  = roll_deg - DEG_W'(REV_START_DEG);

        item.brake_zone = !roll_bits[ROLL_W-1] || (roll_deg < DEG_W'(BRAKE_DEG));
        if (roll_deg < DEG_W'(FWD_FULL_DEG)) begin
            item.fwd_duty = DUTY_MAX;
        end else if (roll_deg < DEG_W'(FWD_ZERO_DEG)) begin
            item.fwd_duty = DUTY_W'(12'(fwd_span[3:0]) * 12'(FWD_GAIN));
        end else begin
            item.fwd_duty = '0;
        end
        if (roll_deg >= DEG_W'(REV_FULL_DEG)) begin
            item.rev_duty = REV_DUTY_MAX;
        end else if (roll_deg > DEG_W'(REV_START_DEG)) begin
            item.rev_duty = rev_table(rev_span[3:0]);
        end else begin
            item.rev_duty = '0;
        end

        angle_diff = {still_angle_reg[ROLL_W-1], still_angle_reg}
                   - {roll_bits[ROLL_W-1], roll_bits};
        angle_mag  = angle_diff[ROLL_W] ? ((ROLL_W+1)'(0) - angle_diff) : angle_diff;

        item.swing_valid = restart && (dir_reg != DIR_STILL);
        item.swing_up    = (dir_reg == DIR_UP);
        item.angle_small = angle_mag < {1'b0, min_swing_angle};
        item.swing_len   = time_ms - still_time_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg         <= DIR_STILL;
            still_angle_reg <= '0;
            still_time_reg  <= '0;
        end else if (accept && restart) begin
            dir_reg         <= cur_dir;
            still_angle_reg <= roll_bits;
            still_time_reg  <= time_ms;
        end
    end

endmodule

// File: hw/rtl/tgamd_queue.sv
// Short first-in first-out queue of classified items between front and back.
// Uses tgamd_pkg for the item type.
module tgamd_queue #(
    parameter int DEPTH = tgamd_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tgamd_pkg::item_t push_item,
    input  logic             pop,
    output tgamd_pkg::item_t pop_item,
    output logic             full,
    output logic             empty
);
    import tgamd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/tgamd_back.sv
// Back end: applies the drive law from the held gesture step, then advances
// the gesture sequence, and holds the result in an output register. Uses tgamd_pkg.
module tgamd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              item_avail,
    input  tgamd_pkg::item_t                  item,
    output logic                              item_take,
    input  logic [tgamd_pkg::CFG_W-1:0]       duration_tolerance,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tgamd_pkg::DUTY_W-1:0]      m_motor_duty,
    output logic                              m_brake_on,
    output logic                              m_reverse_on,
    output logic [tgamd_pkg::STEP_W-1:0]      m_gesture_step
);
    import tgamd_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] fallback_reg, fallback_next;
    logic [TIME_W-1:0] prior_len_reg, prior_len_next;
    logic              rev_latch_reg, rev_latch_next;
    logic              valid_reg;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic              brake_reg, brake_next;

    logic [TIME_W:0]   len_diff;
    logic [TIME_W:0]   len_mag;
    logic              len_match;
    logic              want_up;
    logic [STEP_W-1:0] step_inc;

    assign item_take = item_avail && (!valid_reg || m_ready);

    always_comb begin
        // Drive law from the step held before this sample.
        duty_next      = '0;
        brake_next     = 1'b0;
        rev_latch_next = rev_latch_reg;
        if (step_reg >= STEP_ARMED) begin
            if (item.brake_zone) begin
                brake_next = 1'b1;
            end else if (item.fwd_duty != '0) begin
                duty_next = item.fwd_duty;
            end else if (item.rev_duty != '0) begin
                duty_next      = item.rev_duty;
                rev_latch_next = 1'b1;
            end else begin
                rev_latch_next = 1'b0;
            end
        end else begin
            rev_latch_next = 1'b0;
        end

        len_diff  = {1'b0, item.swing_len} - {1'b0, prior_len_reg};
        len_mag   = len_diff[TIME_W] ? ((TIME_W+1)'(0) - len_diff) : len_diff;
        len_match = len_mag[TIME_W-1:0] < TIME_W'(duration_tolerance);
        want_up   = (step_reg[1:0] == 2'b10);
        step_inc  = step_reg + 1'b1;

        step_next      = step_reg;
        fallback_next  = fallback_reg;
        prior_len_next = prior_len_reg;
        if (item.swing_valid) begin
            // Steps from the top step upwards are left alone by a swing unless its angle is too small.
            if (step_reg < STEP_TOP) begin
                if (step_reg[1:0] == 2'b00) begin
                    if (item.swing_up) begin
                        step_next      = step_inc;
                        prior_len_next = item.swing_len;
                    end
                end else if ((item.swing_up == want_up) && len_match) begin
                    step_next      = step_inc;
                    prior_len_next = item.swing_len;
                    if (step_inc == STEP_ARMED) begin
                        fallback_next = STEP_ARMED;
                    end else if (step_inc == STEP_TOP) begin
                        fallback_next = STEP_IDLE;
                    end
                end else begin
                    step_next = fallback_reg;
                end
            end
            if (item.angle_small) begin
                step_next = fallback_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_IDLE;
            fallback_reg  <= STEP_IDLE;
            prior_len_reg <= '0;
            rev_latch_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            if (item_take) begin
                step_reg      <= step_next;
                fallback_reg  <= fallback_next;
                prior_len_reg <= prior_len_next;
                rev_latch_reg <= rev_latch_next;
                valid_reg     <= 1'b1;
            end else if (m_ready) begin
                valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            duty_reg  <= duty_next;
            brake_reg <= brake_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_motor_duty   = duty_reg;
    assign m_brake_on     = brake_reg;
    assign m_reverse_on   = rev_latch_reg;
    assign m_gesture_step = step_reg;

endmodule

// File: hw/rtl/tilt_gesture_armed_motor_drive_unit.sv
// Tilt gesture armed motor drive, top level: configuration registers, front
// end, item queue and back end. Uses tgamd_pkg, tgamd_front, tgamd_queue, tgamd_back.
//
// The block takes one sensor sample per item (gyro rate, roll angle and a
// millisecond time) and returns exactly one result item for it: motor duty,
// brake, reverse line and the gesture step after the sample. It accepts one
// item every clock cycle for as long as the result side keeps up. The front
// end classifies a sample in the cycle it is accepted and the item is written
// into the queue; the back end steps the gesture sequence when it takes the
// item from the queue, and registers the result, which is held until taken.
// The queue between the two (QUEUE_DEPTH items) lets the input keep flowing
// for that many items while the result side stalls; s_ready drops only when
// the queue is full. The drive outputs of a sample come from the gesture
// step held before that sample; a step of four or more counts as armed.
// Configuration registers (rate threshold, duration tolerance, minimum swing
// angle) are written through cfg_wr_en, cfg_index and cfg_data with no wait
// state, and should only be changed while no item is in flight; a write to
// an index beyond the three registers is ignored.
module tilt_gesture_armed_motor_drive_unit #(
    parameter int QUEUE_DEPTH = tgamd_pkg::QUEUE_DEPTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write port
    input  logic                                   cfg_wr_en,
    input  logic        [tgamd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [tgamd_pkg::CFG_W-1:0]     cfg_data,
    // Sample input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [tgamd_pkg::GYRO_W-1:0]    s_gyro_rate,
    input  logic signed [tgamd_pkg::ROLL_W-1:0]    s_roll_angle,
    input  logic        [tgamd_pkg::TIME_W-1:0]    s_time_ms,
    // Result output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic        [tgamd_pkg::DUTY_W-1:0]    m_motor_duty,
    output logic                                   m_brake_on,
    output logic                                   m_reverse_on,
    output logic        [tgamd_pkg::STEP_W-1:0]    m_gesture_step
);
    import tgamd_pkg::*;

    logic [CFG_W-1:0] rate_threshold_reg;
    logic [CFG_W-1:0] duration_tolerance_reg;
    logic [CFG_W-1:0] min_swing_angle_reg;

    logic  s_accept;
    logic  queue_full;
    logic  queue_empty;
    logic  queue_pop;
    item_t front_item;
    item_t queue_item;

    // Configuration registers; each write lands at the edge it is presented.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_threshold_reg     <= RATE_THRESHOLD_RST;
            duration_tolerance_reg <= DURATION_TOLERANCE_RST;
            min_swing_angle_reg    <= MIN_SWING_ANGLE_RST;
        end else if (cfg_wr_en) begin
            priority if (cfg_index == CFG_RATE_THRESHOLD) begin
                rate_threshold_reg <= cfg_data;
            end else if (cfg_index == CFG_DURATION_TOLERANCE) begin
                duration_tolerance_reg <= cfg_data;
            end else if (cfg_index == CFG_MIN_SWING_ANGLE) begin
                min_swing_angle_reg <= cfg_data;
            end
        end
    end

    // An item is taken whenever the queue has room for it.
    assign s_ready  = !queue_full;
    assign s_accept = s_valid && s_ready;

    tgamd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (s_accept),
        .gyro_rate       (s_gyro_rate),
        .roll_angle      (s_roll_angle),
        .time_ms         (s_time_ms),
        .rate_threshold  (rate_threshold_reg),
        .min_swing_angle (min_swing_angle_reg),
        .item            (front_item)
    );

    tgamd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_item (front_item),
        .pop       (queue_pop),
        .pop_item  (queue_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    tgamd_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .item_avail         (!queue_empty),
        .item               (queue_item),
        .item_take          (queue_pop),
        .duration_tolerance (duration_tolerance_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_motor_duty       (m_motor_duty),
        .m_brake_on         (m_brake_on),
        .m_reverse_on       (m_reverse_on),
        .m_gesture_step     (m_gesture_step)
    );

endmodule
